// ----- src/ctw_pkg.sv -----
`default_nettype none

package ctw_pkg;

  localparam int GRID_COLUMNS_DEF = 128;
  localparam int GRID_ROWS_DEF    = 64;

  localparam int CHAR_W     = 7;
  localparam int ATTR_W     = 7;
  localparam int CELL_W     = CHAR_W + ATTR_W;
  localparam int CODE_W     = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CODE_W-1:0] CH_LF    = 16'd10;
  localparam logic [CODE_W-1:0] CH_CR    = 16'd13;
  localparam logic [CODE_W-1:0] CH_FIRST = 16'd32;
  localparam logic [CODE_W-1:0] CH_LAST  = 16'd126;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_ROWS    = 2'd1;

  localparam logic [7:0] PAGE_COLUMNS_RST = 8'd128;
  localparam logic [6:0] PAGE_ROWS_RST    = 7'd64;

endpackage

`default_nettype wire

// ----- src/ctw_cell_ram.sv -----
`default_nettype none

module ctw_cell_ram #(
  parameter int DEPTH = ctw_pkg::GRID_COLUMNS_DEF * ctw_pkg::GRID_ROWS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [AW-1:0]              wr_addr,
  input  wire logic [ctw_pkg::CELL_W-1:0] wr_data,
  input  wire logic [AW-1:0]              rd_addr,
  output logic      [ctw_pkg::CELL_W-1:0] rd_data
);
  import ctw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- src/text_cell_terminal_writer.sv -----
`default_nettype none

// Character-cell terminal buffer over a GRID_ROWS x GRID_COLUMNS single-port-write cell
// memory, driven by a small sequencer that takes one item at a time (in_tready is high only
// when idle; a finished result may wait in the output register meanwhile). A CR, a rejected
// character, an unused command or a read outside the grid goes from decode straight to the
// result; a stored character passes address and write states, an in-grid read address
// and memory-read states. A row advance that scrolls walks the memory: each cell of the
// page below page row 0 is copied up one row, then the last page row is blanked. A clear
// blanks the whole grid. After reset the block runs a clearing pass over the whole grid
// before it takes the first item; configuration writes are taken at any time.
module text_cell_terminal_writer #(
  parameter int GRID_COLUMNS = ctw_pkg::GRID_COLUMNS_DEF,
  parameter int GRID_ROWS    = ctw_pkg::GRID_ROWS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // char_code[15:0], char_attribute[22:16], read_row[28:23], read_column[35:29]
  input  wire logic [ctw_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  wire logic [ctw_pkg::CMD_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // status[0], cursor_row[6:1], cursor_column[14:7], scrolled[15],
  // cell_char[22:16], cell_attribute[29:23]
  output logic      [ctw_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ctw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ctw_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ctw_pkg::*;

  localparam int CELLS = GRID_COLUMNS * GRID_ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int RW    = $clog2(GRID_ROWS);
  localparam int CW    = $clog2(GRID_COLUMNS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCROLL,
    S_COPY_RD,
    S_COPY_WR,
    S_CLR,
    S_ADDR,
    S_WR,
    S_RD_MEM,
    S_DONE
  } state_t;

  state_t                 state_r;
  cmd_t                   cmd_r;
  logic [CODE_W-1:0]      code_r;
  logic [ATTR_W-1:0]      attr_r;
  logic [5:0]             rrow_r;
  logic [6:0]             rcol_r;
  logic                   status_r;
  logic                   scrolled_r;
  logic                   rd_ok_r;
  logic [RW-1:0]          row_r;
  logic [CW-1:0]          col_r;
  logic [AW-1:0]          ptr_r;
  logic [AW-1:0]          base_r;
  logic [AW-1:0]          clr_last_r;
  logic [AW-1:0]          addr_r;
  logic                   init_r;
  logic                   out_tvalid_r;
  logic [OUT_DATA_W-1:0]  out_tdata_r;
  logic [7:0]             page_columns_r;
  logic [6:0]             page_rows_r;

  logic                   is_print;
  logic                   wrap;
  logic [RW-1:0]          eff_rows_m1;
  logic                   rd_in_grid;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [CELL_W-1:0]      wr_data;
  logic [AW-1:0]          rd_addr;
  logic [CELL_W-1:0]      rd_data;
  logic [CHAR_W-1:0]      cell_char;
  logic [ATTR_W-1:0]      cell_attr;

  assign is_print   = (cmd_r == CMD_PUT) && (code_r >= CH_FIRST) && (code_r <= CH_LAST);
  assign rd_in_grid = (32'(rrow_r) < GRID_ROWS) && (32'(rcol_r) < GRID_COLUMNS);

  always_comb begin
    priority if (page_columns_r == '0) begin
      wrap = (col_r != '0);
    end else if (32'(page_columns_r) > GRID_COLUMNS) begin
      wrap = (32'(col_r) >= GRID_COLUMNS);
    end else begin
      wrap = (32'(col_r) >= 32'(page_columns_r));
    end
  end

  always_comb begin
    priority if (page_rows_r == '0) begin
      eff_rows_m1 = '0;
    end else if (32'(page_rows_r) > GRID_ROWS) begin
      eff_rows_m1 = RW'(GRID_ROWS - 1);
    end else begin
      eff_rows_m1 = RW'(32'(page_rows_r) - 32'd1);
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_r;
    wr_data = '0;
    rd_addr = addr_r;
    unique case (state_r)
      S_COPY_RD: begin
        rd_addr = AW'(32'(ptr_r) + GRID_COLUMNS);
      end
      S_COPY_WR: begin
        wr_en   = 1'b1;
        wr_data = rd_data;
      end
      S_CLR: begin
        wr_en = 1'b1;
      end
      S_WR: begin
        wr_en   = 1'b1;
        wr_addr = addr_r;
        wr_data = {attr_r, code_r[CHAR_W-1:0]};
      end
      default: begin
      end
    endcase
  end

  ctw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign cell_char = rd_ok_r ? rd_data[CHAR_W-1:0] : '0;
  assign cell_attr = rd_ok_r ? rd_data[CELL_W-1:CHAR_W] : '0;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_columns_r <= PAGE_COLUMNS_RST;
      page_rows_r    <= PAGE_ROWS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PAGE_COLUMNS: page_columns_r <= cfg_data;
        REG_PAGE_ROWS:    page_rows_r    <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      init_r       <= 1'b1;
      ptr_r        <= '0;
      clr_last_r   <= AW'(CELLS - 1);
      row_r        <= '0;
      col_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r      <= cmd_t'(in_tuser);
            code_r     <= in_tdata[15:0];
            attr_r     <= in_tdata[22:16];
            rrow_r     <= in_tdata[28:23];
            rcol_r     <= in_tdata[35:29];
            status_r   <= 1'b0;
            scrolled_r <= 1'b0;
            rd_ok_r    <= 1'b0;
            state_r    <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (cmd_r)
            CMD_PUT: begin
              priority if (code_r == CH_CR) begin
                col_r   <= '0;
                state_r <= S_DONE;
              end else if ((code_r == CH_LF) || (is_print && wrap)) begin
                col_r <= '0;
                if (row_r >= eff_rows_m1) begin
                  row_r      <= eff_rows_m1;
                  scrolled_r <= 1'b1;
                  state_r    <= S_SCROLL;
                end else begin
                  row_r   <= row_r + 1'b1;
                  state_r <= is_print ? S_ADDR : S_DONE;
                end
              end else if (is_print) begin
                state_r <= S_ADDR;
              end else begin
                status_r <= 1'b1;
                state_r  <= S_DONE;
              end
            end
            CMD_READ: begin
              rd_ok_r <= rd_in_grid;
              state_r <= rd_in_grid ? S_ADDR : S_DONE;
            end
            CMD_CLEAR: begin
              row_r      <= '0;
              col_r      <= '0;
              ptr_r      <= '0;
              clr_last_r <= AW'(CELLS - 1);
              state_r    <= S_CLR;
            end
            CMD_NOP: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_SCROLL: begin
          base_r  <= AW'(32'(row_r) * GRID_COLUMNS);
          ptr_r   <= '0;
          state_r <= S_COPY_RD;
        end
        S_COPY_RD: begin
          if (ptr_r == base_r) begin
            clr_last_r <= AW'(32'(base_r) + GRID_COLUMNS - 1);
            state_r    <= S_CLR;
          end else begin
            state_r <= S_COPY_WR;
          end
        end
        S_COPY_WR: begin
          ptr_r   <= ptr_r + 1'b1;
          state_r <= S_COPY_RD;
        end
        S_CLR: begin
          if (ptr_r == clr_last_r) begin
            priority if (init_r) begin
              init_r  <= 1'b0;
              state_r <= S_IDLE;
            end else if (is_print) begin
              state_r <= S_ADDR;
            end else begin
              state_r <= S_DONE;
            end
          end else begin
            ptr_r <= ptr_r + 1'b1;
          end
        end
        S_ADDR: begin
          if (cmd_r == CMD_READ) begin
            addr_r  <= AW'(32'(rrow_r) * GRID_COLUMNS + 32'(rcol_r));
            state_r <= S_RD_MEM;
          end else begin
            addr_r  <= AW'(32'(row_r) * GRID_COLUMNS + 32'(col_r));
            state_r <= S_WR;
          end
        end
        S_WR: begin
          col_r   <= col_r + 1'b1;
          state_r <= S_DONE;
        end
        S_RD_MEM: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r  <= {2'b00, cell_attr, cell_char, scrolled_r, 8'(col_r), 6'(row_r),
                             status_r};
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sequencer took an item while busy");

  a_copy_below_base: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY_WR) |-> (ptr_r < base_r))
    else $error("scroll copy wrote at or past the last page row");

  a_clear_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> (ptr_r <= clr_last_r))
    else $error("clear pass ran past its end");

  a_ready_after_init: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !init_r)
    else $error("item taken before the reset clearing pass finished");

  a_column_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (32'(col_r) < GRID_COLUMNS))
    else $error("character stored outside the grid");

endmodule

`default_nettype wire
